@@ rtl/axis_angle_rotate_mat4_assert.svh @@
// Assertion macros shared by the checkers of this block.
`ifndef AXIS_ANGLE_ROTATE_MAT4_ASSERT_SVH
`define AXIS_ANGLE_ROTATE_MAT4_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define AAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define AAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aar_pkg.sv @@
package aar_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_W     = 32;
  localparam int ANGLE_W    = 16;
  localparam int COEF_W     = 20;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int LEN_W      = 64;
  localparam int ZANG_W     = 33;
  localparam int STEP_W     = 5;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_Q_BITS = FRAC_BITS + 2;

  localparam logic [1:0] COL_LAST = 2'd3;
  localparam logic [1:0] COL_FIRST = 2'd0;

  localparam int GAIN_Q30 = 652032874;
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);
  localparam logic signed [COEF_W-1:0] CORDIC_X0 =
    COEF_W'((GAIN_Q30 + (1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS));

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_COR_DONE,
    OP_US,
    OP_PP,
    OP_RT,
    OP_MAC,
    OP_RES,
    OP_COPY
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_ZCHK,
    ST_SQRT,
    ST_DIV,
    ST_COR,
    ST_US,
    ST_COEF,
    ST_MAC,
    ST_COPY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       col;
    logic [1:0]       row;
    logic [3:0]       ridx;
    logic [STEP_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic zero;
  } sts_t;

  // Arctangent of 2^-i, in units of 2^-32 turn.
  function automatic logic signed [ZANG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [ZANG_W-1:0] v;
    case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933405;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335086;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41721;
      5'd15: v = 33'sd20860;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2607;
      5'd19: v = 33'sd1303;
      5'd20: v = 33'sd651;
      5'd21: v = 33'sd325;
      5'd22: v = 33'sd162;
      5'd23: v = 33'sd81;
      5'd24: v = 33'sd40;
      5'd25: v = 33'sd20;
      5'd26: v = 33'sd10;
      5'd27: v = 33'sd5;
      5'd28: v = 33'sd2;
      5'd29: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/aar_ctrl.sv @@
module aar_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_column_index,
  input  logic          out_stall,
  input  aar_pkg::sts_t sts,
  output logic          in_stall,
  output logic          out_valid,
  output aar_pkg::cmd_t cmd
);

  localparam logic [aar_pkg::STEP_W-1:0] LEN_END  = 5'd5;
  localparam logic [aar_pkg::STEP_W-1:0] SQRT_END = 5'd31;
  localparam logic [aar_pkg::STEP_W-1:0] DIV_END  = aar_pkg::STEP_W'(aar_pkg::DIV_Q_BITS + 1);
  localparam logic [aar_pkg::STEP_W-1:0] COR_END  = aar_pkg::STEP_W'(aar_pkg::CORDIC_STEPS + 1);
  localparam logic [aar_pkg::STEP_W-1:0] MAC_END  = 5'd4;
  localparam logic [3:0] LAST_ELEM = 4'd11;
  localparam logic [3:0] LAST_COEF = 4'b1010;

  aar_pkg::state_t state_r, state_nxt;
  logic [aar_pkg::STEP_W-1:0] idx_r, idx_nxt;
  logic [3:0] n_r, n_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aar_pkg::ST_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    unique case (state_r)
      aar_pkg::ST_IDLE: begin
        if (in_valid && in_column_index == aar_pkg::COL_LAST) begin
          state_nxt = aar_pkg::ST_LEN;
          idx_nxt   = '0;
        end
      end
      aar_pkg::ST_LEN: begin
        if (idx_r == LEN_END) state_nxt = aar_pkg::ST_ZCHK;
        else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_ZCHK: begin
        idx_nxt = '0;
        n_nxt   = '0;
        state_nxt = sts.zero ? aar_pkg::ST_COPY : aar_pkg::ST_SQRT;
      end
      aar_pkg::ST_SQRT: begin
        if (idx_r == SQRT_END) begin
          state_nxt = aar_pkg::ST_DIV;
          idx_nxt   = '0;
          n_nxt     = '0;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_DIV: begin
        if (idx_r == DIV_END) begin
          idx_nxt = '0;
          if (n_r == 4'd2) state_nxt = aar_pkg::ST_COR;
          else n_nxt = n_r + 1'b1;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_COR: begin
        if (idx_r == COR_END) begin
          state_nxt = aar_pkg::ST_US;
          idx_nxt   = '0;
          n_nxt     = '0;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_US: begin
        if (idx_r[0]) begin
          idx_nxt = '0;
          if (n_r == 4'd2) begin
            state_nxt = aar_pkg::ST_COEF;
            n_nxt     = '0;
          end else n_nxt = n_r + 1'b1;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_COEF: begin
        // n holds {row of u, column of u}, column wraps at two
        if (idx_r == 5'd3) begin
          idx_nxt = '0;
          if (n_r == LAST_COEF) begin
            state_nxt = aar_pkg::ST_MAC;
            n_nxt     = '0;
          end else if (n_r[1:0] == 2'd2) n_nxt = {n_r[3:2] + 1'b1, 2'd0};
          else n_nxt = n_r + 1'b1;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_MAC: begin
        if (idx_r == MAC_END) begin
          idx_nxt = '0;
          if (n_r == LAST_ELEM) begin
            state_nxt = aar_pkg::ST_EMIT;
            n_nxt     = '0;
          end else n_nxt = n_r + 1'b1;
        end else idx_nxt = idx_r + 1'b1;
      end
      aar_pkg::ST_COPY: begin
        if (n_r == LAST_ELEM) begin
          state_nxt = aar_pkg::ST_EMIT;
          n_nxt     = '0;
        end else n_nxt = n_r + 1'b1;
      end
      aar_pkg::ST_EMIT: begin
        if (!out_stall) begin
          if (n_r[1:0] == aar_pkg::COL_LAST) begin
            state_nxt = aar_pkg::ST_IDLE;
            n_nxt     = '0;
          end else n_nxt = n_r + 1'b1;
        end
      end
      default: state_nxt = aar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != aar_pkg::ST_IDLE);
    out_valid = (state_r == aar_pkg::ST_EMIT);
    cmd.op    = aar_pkg::OP_NOP;
    cmd.col   = '0;
    cmd.row   = '0;
    cmd.ridx  = '0;
    cmd.cnt   = '0;
    unique case (state_r)
      aar_pkg::ST_IDLE: begin
        if (in_valid) cmd.op = aar_pkg::OP_LOAD;
      end
      aar_pkg::ST_LEN: begin
        if (!idx_r[0]) cmd.op = aar_pkg::OP_SQ;
        cmd.col = idx_r[2:1];
      end
      aar_pkg::ST_ZCHK: cmd.op = aar_pkg::OP_SQRT_INIT;
      aar_pkg::ST_SQRT: cmd.op = aar_pkg::OP_SQRT_STEP;
      aar_pkg::ST_DIV: begin
        cmd.col = n_r[1:0];
        if (idx_r == '0) cmd.op = aar_pkg::OP_DIV_INIT;
        else if (idx_r == DIV_END) cmd.op = aar_pkg::OP_DIV_DONE;
        else cmd.op = aar_pkg::OP_DIV_STEP;
      end
      aar_pkg::ST_COR: begin
        cmd.cnt = idx_r - 1'b1;
        if (idx_r == '0) cmd.op = aar_pkg::OP_COR_INIT;
        else if (idx_r == COR_END) cmd.op = aar_pkg::OP_COR_DONE;
        else cmd.op = aar_pkg::OP_COR_STEP;
      end
      aar_pkg::ST_US: begin
        cmd.col = n_r[1:0];
        if (!idx_r[0]) cmd.op = aar_pkg::OP_US;
      end
      aar_pkg::ST_COEF: begin
        cmd.col  = n_r[1:0];
        cmd.row  = n_r[3:2];
        cmd.ridx = {1'b0, n_r[3:2], 1'b0} + {2'b0, n_r[3:2]} + {2'b0, n_r[1:0]};
        if (idx_r == 5'd0) cmd.op = aar_pkg::OP_PP;
        else if (idx_r == 5'd2) cmd.op = aar_pkg::OP_RT;
      end
      aar_pkg::ST_MAC: begin
        cmd.row  = n_r[1:0];
        cmd.ridx = {1'b0, n_r[3:2], 1'b0} + {2'b0, n_r[3:2]} + {2'b0, idx_r[1:0]};
        if (idx_r < 5'd3) begin
          cmd.op  = aar_pkg::OP_MAC;
          cmd.col = idx_r[1:0];
        end else if (idx_r == MAC_END) begin
          cmd.op  = aar_pkg::OP_RES;
          cmd.col = n_r[3:2];
        end
      end
      aar_pkg::ST_COPY: begin
        cmd.op  = aar_pkg::OP_COPY;
        cmd.col = n_r[3:2];
        cmd.row = n_r[1:0];
      end
      aar_pkg::ST_EMIT: cmd.col = n_r[1:0];
      default: cmd.op = aar_pkg::OP_NOP;
    endcase
  end

endmodule

@@ rtl/aar_dp.sv @@
module aar_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aar_pkg::cmd_t                    cmd,
  output aar_pkg::sts_t                    sts,
  input  logic [1:0]                       in_column_index,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem0,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem1,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem2,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem3,
  input  logic [aar_pkg::ANGLE_W-1:0]      in_turn_angle,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_x,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_y,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_z,
  output logic [1:0]                       out_column,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res0,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res1,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res2,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res3,
  output logic                             out_last_column,
  output logic                             out_zero_axis,
  output logic                             out_saturated
);

  localparam int FB = aar_pkg::FRAC_BITS;
  localparam int QB = aar_pkg::DIV_Q_BITS;
  localparam int NUM_W = aar_pkg::ELEM_W + FB;

  aar_pkg::elem_t store_r [0:2][0:3];
  aar_pkg::elem_t res_r [0:3][0:3];
  logic [3:0] sat_r;
  logic [aar_pkg::ANGLE_W-1:0] ang_r;
  aar_pkg::elem_t ax_r [0:2];

  logic [aar_pkg::LEN_W-1:0] len2_r, sq_rem_r, sq_root_r, sq_bit_r;
  logic [NUM_W-1:0] dnum_r;
  logic [aar_pkg::ELEM_W:0] drem_r;
  logic [QB-1:0] dquo_r;
  logic dneg_r;

  aar_pkg::coef_t u_r [0:2];
  aar_pkg::coef_t us_r [0:2];
  aar_pkg::coef_t r_r [0:8];
  aar_pkg::coef_t c_r, s_r, t_r, pp_r, cx_r, cy_r;
  logic signed [aar_pkg::ZANG_W-1:0] cz_r;
  logic cflip_r;

  logic signed [aar_pkg::PROD_W-1:0] prod_r;
  aar_pkg::op_t pop_r;
  logic [1:0] pcol_r;
  logic [3:0] pridx_r;
  logic signed [aar_pkg::ACC_W-1:0] acc_r;

  function automatic aar_pkg::coef_t clamp_one(input logic signed [aar_pkg::COEF_W:0] v);
    aar_pkg::coef_t o;
    if (v > (aar_pkg::COEF_W + 1)'(aar_pkg::COEF_ONE)) o = aar_pkg::COEF_ONE;
    else if (v < -(aar_pkg::COEF_W + 1)'(aar_pkg::COEF_ONE)) o = -aar_pkg::COEF_ONE;
    else o = aar_pkg::COEF_W'(v);
    return o;
  endfunction

  // Multiplier operands
  logic signed [aar_pkg::MUL_W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      aar_pkg::OP_SQ: begin
        mul_a = aar_pkg::MUL_W'(ax_r[cmd.col]);
        mul_b = aar_pkg::MUL_W'(ax_r[cmd.col]);
      end
      aar_pkg::OP_US: begin
        mul_a = aar_pkg::MUL_W'(u_r[cmd.col]);
        mul_b = aar_pkg::MUL_W'(s_r);
      end
      aar_pkg::OP_PP: begin
        mul_a = aar_pkg::MUL_W'(u_r[cmd.col]);
        mul_b = aar_pkg::MUL_W'(u_r[cmd.row]);
      end
      aar_pkg::OP_RT: begin
        mul_a = aar_pkg::MUL_W'(pp_r);
        mul_b = aar_pkg::MUL_W'(t_r);
      end
      aar_pkg::OP_MAC: begin
        mul_a = aar_pkg::MUL_W'(store_r[cmd.col][cmd.row]);
        mul_b = aar_pkg::MUL_W'(r_r[cmd.ridx]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [aar_pkg::PROD_W-1:0] prod_rnd;
  aar_pkg::coef_t prod_q, rt_add;
  logic signed [aar_pkg::COEF_W:0] rt_sum;
  assign prod_rnd = (prod_r + (aar_pkg::PROD_W'(1) <<< (FB - 1))) >>> FB;
  assign prod_q   = aar_pkg::COEF_W'(prod_rnd);

  always_comb begin
    case (pridx_r)
      4'd1: rt_add = us_r[2];
      4'd2: rt_add = -us_r[1];
      4'd3: rt_add = -us_r[2];
      4'd5: rt_add = us_r[0];
      4'd6: rt_add = us_r[1];
      4'd7: rt_add = -us_r[0];
      default: rt_add = c_r;
    endcase
  end
  assign rt_sum = (aar_pkg::COEF_W + 1)'(prod_q) + (aar_pkg::COEF_W + 1)'(rt_add);

  // Result column rounding and clipping
  logic signed [aar_pkg::ACC_W-1:0] acc_rnd;
  logic acc_fits;
  aar_pkg::elem_t acc_clip;
  assign acc_rnd  = (acc_r + (aar_pkg::ACC_W'(1) <<< (FB - 1))) >>> FB;
  assign acc_fits = (&acc_rnd[aar_pkg::ACC_W-1:aar_pkg::ELEM_W-1])
                  | ~(|acc_rnd[aar_pkg::ACC_W-1:aar_pkg::ELEM_W-1]);
  assign acc_clip = acc_fits ? aar_pkg::ELEM_W'(acc_rnd)
                  : (acc_rnd[aar_pkg::ACC_W-1] ? {1'b1, {(aar_pkg::ELEM_W-1){1'b0}}}
                                               : {1'b0, {(aar_pkg::ELEM_W-1){1'b1}}});

  // Square root and divider steps
  logic [aar_pkg::LEN_W-1:0] sq_try;
  logic sq_ge;
  assign sq_try = sq_root_r + sq_bit_r;
  assign sq_ge  = (sq_rem_r >= sq_try);

  logic [aar_pkg::ELEM_W-1:0] qv;
  logic [aar_pkg::ELEM_W+1:0] dtrial;
  logic dge;
  logic [aar_pkg::ELEM_W-1:0] mag;
  logic [NUM_W-1:0] dnum0;
  aar_pkg::elem_t ax_sel;
  assign qv     = sq_root_r[aar_pkg::ELEM_W-1:0];
  assign dtrial = {drem_r, dnum_r[QB-1]};
  assign dge    = (dtrial >= {2'b00, qv});
  assign ax_sel = ax_r[cmd.col];
  assign mag    = ax_sel[aar_pkg::ELEM_W-1] ? aar_pkg::ELEM_W'(-ax_sel) : ax_sel;
  assign dnum0  = {mag, {FB{1'b0}}} + NUM_W'(qv >> 1);

  // CORDIC step
  aar_pkg::coef_t cdx, cdy, cxf, cyf;
  logic signed [aar_pkg::ANGLE_W-1:0] fang;
  logic fflip;
  assign cdx   = cy_r >>> cmd.cnt;
  assign cdy   = cx_r >>> cmd.cnt;
  assign fflip = ang_r[aar_pkg::ANGLE_W-1] ^ ang_r[aar_pkg::ANGLE_W-2];
  // fold to a quarter turn around zero or half a turn
  assign fang  = fflip ? {~ang_r[aar_pkg::ANGLE_W-1], ang_r[aar_pkg::ANGLE_W-2:0]} : ang_r;
  assign cxf   = cflip_r ? -cx_r : cx_r;
  assign cyf   = cflip_r ? -cy_r : cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r  <= aar_pkg::OP_NOP;
      sat_r  <= '0;
      ang_r  <= '0;
      len2_r <= '0;
      for (int i = 0; i < 3; i++) ax_r[i] <= '0;
    end else begin
      pop_r   <= cmd.op;
      pcol_r  <= cmd.col;
      pridx_r <= cmd.ridx;
      prod_r  <= mul_a * mul_b;

      // consume the product issued last cycle
      case (pop_r)
        aar_pkg::OP_SQ:  len2_r <= len2_r + aar_pkg::LEN_W'(prod_r);
        aar_pkg::OP_US:  us_r[pcol_r] <= prod_q;
        aar_pkg::OP_PP:  pp_r <= prod_q;
        aar_pkg::OP_RT:  r_r[pridx_r] <= clamp_one(rt_sum);
        aar_pkg::OP_MAC: acc_r <= (pcol_r == 2'd0) ? aar_pkg::ACC_W'(prod_r)
                                                   : acc_r + aar_pkg::ACC_W'(prod_r);
        default: ;
      endcase

      case (cmd.op)
        aar_pkg::OP_LOAD: begin
          if (in_column_index == aar_pkg::COL_LAST) begin
            res_r[3][0] <= in_elem0;
            res_r[3][1] <= in_elem1;
            res_r[3][2] <= in_elem2;
            res_r[3][3] <= in_elem3;
            len2_r <= '0;
            sat_r  <= '0;
          end else begin
            store_r[in_column_index][0] <= in_elem0;
            store_r[in_column_index][1] <= in_elem1;
            store_r[in_column_index][2] <= in_elem2;
            store_r[in_column_index][3] <= in_elem3;
            if (in_column_index == aar_pkg::COL_FIRST) begin
              ang_r   <= in_turn_angle;
              ax_r[0] <= in_axis_x;
              ax_r[1] <= in_axis_y;
              ax_r[2] <= in_axis_z;
            end
          end
        end
        aar_pkg::OP_SQRT_INIT: begin
          sq_rem_r  <= len2_r;
          sq_root_r <= '0;
          sq_bit_r  <= aar_pkg::LEN_W'(1) << (aar_pkg::LEN_W - 2);
        end
        aar_pkg::OP_SQRT_STEP: begin
          if (sq_ge) begin
            sq_rem_r  <= sq_rem_r - sq_try;
            sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
          end else begin
            sq_root_r <= sq_root_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end
        aar_pkg::OP_DIV_INIT: begin
          dnum_r <= dnum0;
          drem_r <= (aar_pkg::ELEM_W + 1)'(dnum0[NUM_W-1:QB]);
          dquo_r <= '0;
          dneg_r <= ax_sel[aar_pkg::ELEM_W-1];
        end
        aar_pkg::OP_DIV_STEP: begin
          drem_r <= dge ? (aar_pkg::ELEM_W + 1)'(dtrial - {2'b00, qv})
                        : (aar_pkg::ELEM_W + 1)'(dtrial);
          dquo_r <= {dquo_r[QB-2:0], dge};
          dnum_r <= dnum_r << 1;
        end
        aar_pkg::OP_DIV_DONE: begin
          u_r[cmd.col] <= dneg_r ? -aar_pkg::coef_t'({2'b00, dquo_r})
                                 : aar_pkg::coef_t'({2'b00, dquo_r});
        end
        aar_pkg::OP_COR_INIT: begin
          cx_r    <= aar_pkg::CORDIC_X0;
          cy_r    <= '0;
          cz_r    <= {fang[aar_pkg::ANGLE_W-1], fang, {aar_pkg::ANGLE_W{1'b0}}};
          cflip_r <= fflip;
        end
        aar_pkg::OP_COR_STEP: begin
          if (!cz_r[aar_pkg::ZANG_W-1]) begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - aar_pkg::atan_turn(cmd.cnt);
          end else begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + aar_pkg::atan_turn(cmd.cnt);
          end
        end
        aar_pkg::OP_COR_DONE: begin
          c_r <= clamp_one((aar_pkg::COEF_W + 1)'(cxf));
          s_r <= clamp_one((aar_pkg::COEF_W + 1)'(cyf));
          t_r <= aar_pkg::COEF_ONE - clamp_one((aar_pkg::COEF_W + 1)'(cxf));
        end
        aar_pkg::OP_RES: begin
          res_r[cmd.col][cmd.row] <= acc_clip;
          sat_r[cmd.col] <= sat_r[cmd.col] | ~acc_fits;
        end
        aar_pkg::OP_COPY: res_r[cmd.col][cmd.row] <= store_r[cmd.col][cmd.row];
        default: ;
      endcase
    end
  end

  assign sts.zero        = (len2_r == '0);
  assign out_column      = cmd.col;
  assign out_last_column = (cmd.col == aar_pkg::COL_LAST);
  assign out_zero_axis   = sts.zero;
  assign out_saturated   = sat_r[cmd.col];
  assign out_res0        = res_r[cmd.col][0];
  assign out_res1        = res_r[cmd.col][1];
  assign out_res2        = res_r[cmd.col][2];
  assign out_res3        = res_r[cmd.col][3];

endmodule

@@ rtl/axis_angle_rotate_mat4.sv @@
// Post-multiplies a column-major 4x4 Q16.16 matrix by the rotation of a 16-bit
// binary angle about a normalized axis. Columns arrive one per beat; columns 0-2
// are stored as they arrive, and column 0 also latches angle and axis. Column 3
// starts the work: the squared axis length, a zero check, the bit-serial square
// root, three 18-step divisions and the 16-step CORDIC, then work on the single
// shared multiplier (unit axis times sine, nine coefficients, 36 multiply-adds),
// before four result beats go out. A zero axis skips to a copy of the stored
// columns. Input is stalled from column 3 until the last result beat is taken.
module axis_angle_rotate_mat4 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_column_index,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem0,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem1,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem2,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_elem3,
  input  logic [aar_pkg::ANGLE_W-1:0]      in_turn_angle,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_x,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_y,
  input  logic signed [aar_pkg::ELEM_W-1:0] in_axis_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_column,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res0,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res1,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res2,
  output logic signed [aar_pkg::ELEM_W-1:0] out_res3,
  output logic                             out_last_column,
  output logic                             out_zero_axis,
  output logic                             out_saturated
);

  aar_pkg::cmd_t cmd;
  aar_pkg::sts_t sts;

  aar_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_column_index (in_column_index),
    .out_stall       (out_stall),
    .sts             (sts),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .cmd             (cmd)
  );

  aar_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_column_index (in_column_index),
    .in_elem0        (in_elem0),
    .in_elem1        (in_elem1),
    .in_elem2        (in_elem2),
    .in_elem3        (in_elem3),
    .in_turn_angle   (in_turn_angle),
    .in_axis_x       (in_axis_x),
    .in_axis_y       (in_axis_y),
    .in_axis_z       (in_axis_z),
    .out_column      (out_column),
    .out_res0        (out_res0),
    .out_res1        (out_res1),
    .out_res2        (out_res2),
    .out_res3        (out_res3),
    .out_last_column (out_last_column),
    .out_zero_axis   (out_zero_axis),
    .out_saturated   (out_saturated)
  );

endmodule

@@ rtl/aar_chk.sv @@
`include "axis_angle_rotate_mat4_assert.svh"

module aar_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_column,
  input logic signed [aar_pkg::ELEM_W-1:0] out_res0,
  input logic                             out_last_column
);

  // hold a stalled result beat
  `AAR_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_res0) && $stable(out_column),
                  "stalled result beat changed")

  `AAR_ASSERT_IMP(a_no_in_while_out, out_valid, in_stall, "input taken while results pending")

  `AAR_ASSERT_IMP(a_last_flag, out_valid,
                  out_last_column == (out_column == aar_pkg::COL_LAST),
                  "last flag mismatch")

  // beats of one matrix follow each other, and end after the last
  `AAR_ASSERT_NXT(a_end, out_valid && !out_stall && out_last_column, !out_valid,
                  "extra beat after last column")

  `AAR_ASSERT_NXT(a_burst, out_valid && !out_stall && !out_last_column, out_valid,
                  "result burst broken")

endmodule

bind axis_angle_rotate_mat4 aar_chk u_aar_chk (.*);
